// ----- sv/pfbr_pkg.sv -----
// Package for the packet FIFO byte ring: sizes, codes, bookkeeping structs
// and pointer helpers. Depends on nothing; each file but pfbr_ram imports it.
package pfbr_pkg;

   // Sizing
   localparam int BUFFER_BYTES = 256;
   localparam int MAX_PACKET   = 64;
   localparam int MAX_PACKETS  = 16;

   // Fixed field widths
   localparam int ACT_W   = 2;
   localparam int ID_W    = 32;
   localparam int PLEN_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 8;
   localparam int LEN_W   = 7;
   localparam int STAT_W  = 2;

   // Derived widths
   localparam int PTR_W       = $clog2(BUFFER_BYTES);
   localparam int USED_W      = $clog2(BUFFER_BYTES + 1);
   localparam int DESC_W      = $clog2(MAX_PACKETS);
   localparam int CNT_W       = $clog2(MAX_PACKETS + 1);
   localparam int ADD_W       = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
   localparam int CMP_W       = USED_W + PLEN_W;
   localparam int DESC_DATA_W = ID_W + LEN_W;

   localparam logic [USED_W-1:0] BUF_SIZE = USED_W'(BUFFER_BYTES);

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_START = 2'd0,
      ACT_PUSH_DATA  = 2'd1,
      ACT_POP        = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_ACCEPTED = 2'd0,
      ST_REJECTED = 2'd1,
      ST_POPPED   = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DESC,
      SEQ_STREAM
   } seq_state_type;

   // Ring bookkeeping seen by the pop sequencer and the memories
   typedef struct packed {
      logic [PTR_W-1:0]  rd_ptr;
      logic [PTR_W-1:0]  wr_ptr;
      logic [DESC_W-1:0] head;
      logic [DESC_W-1:0] tail;
      logic [CNT_W-1:0]  count;
      logic [USED_W-1:0] used;
      logic              open;
   } ring_state_type;

   // Release of the oldest packet at the end of a pop
   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
   } pop_done_type;

   function automatic logic [PTR_W-1:0] byte_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(BUFFER_BYTES - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [DESC_W-1:0] desc_next(input logic [DESC_W-1:0] p);
      return (p == DESC_W'(MAX_PACKETS - 1)) ? '0 : p + DESC_W'(1);
   endfunction

   // Advance a byte pointer by a whole packet; n never exceeds the ring size
   function automatic logic [PTR_W-1:0] byte_advance(input logic [PTR_W-1:0] p,
                                                     input logic [LEN_W-1:0] n);
      logic [ADD_W-1:0] sum;
      sum = ADD_W'(p) + ADD_W'(n);
      if (sum >= ADD_W'(BUFFER_BYTES)) begin
         sum = sum - ADD_W'(BUFFER_BYTES);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

// ----- sv/pfbr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pfbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pfbr_ring.sv -----
// Ring bookkeeping: byte pointers, fill level, descriptor queue indexes and
// the open-packet tracker. Depends on pfbr_pkg.
module pfbr_ring (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start_take,
   input  logic                           data_take,
   input  logic [pfbr_pkg::PLEN_W-1:0]    packet_len,
   input  pfbr_pkg::pop_done_type         pop_done,
   output logic                           push_ok,
   output logic                           byte_we,
   output pfbr_pkg::ring_state_type       ring
);
   import pfbr_pkg::*;

   logic [PTR_W-1:0]  rd_ptr_ff,  rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff,  wr_ptr_in;
   logic [DESC_W-1:0] head_ff,    head_in;
   logic [DESC_W-1:0] tail_ff,    tail_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic [USED_W-1:0] used_ff,    used_in;
   logic [LEN_W-1:0]  pending_ff, pending_in;
   logic              open_ff,    open_in;
   logic [USED_W-1:0] avail;

   assign avail   = BUF_SIZE - used_ff;
   assign push_ok = !open_ff
                    && (packet_len <= PLEN_W'(MAX_PACKET))
                    && (CMP_W'(packet_len) <= CMP_W'(avail))
                    && (count_ff < CNT_W'(MAX_PACKETS));
   assign byte_we = data_take && open_ff && (pending_ff != '0) && (used_ff < BUF_SIZE);

   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      used_in    = used_ff;
      pending_in = pending_ff;
      open_in    = open_ff;
      if (start_take && push_ok) begin
         if (packet_len == '0) begin
            tail_in  = desc_next(tail_ff);
            count_in = count_ff + CNT_W'(1);
         end else begin
            open_in    = 1'b1;
            pending_in = packet_len[LEN_W-1:0];
         end
      end
      if (byte_we) begin
         wr_ptr_in  = byte_next(wr_ptr_ff);
         used_in    = used_ff + USED_W'(1);
         pending_in = pending_ff - LEN_W'(1);
         if (pending_ff == LEN_W'(1)) begin
            tail_in  = desc_next(tail_ff);
            count_in = count_ff + CNT_W'(1);
            open_in  = 1'b0;
         end
      end
      if (pop_done.valid) begin
         rd_ptr_in = byte_advance(rd_ptr_ff, pop_done.len);
         used_in   = used_ff - USED_W'(pop_done.len);
         head_in   = desc_next(head_ff);
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         used_ff    <= '0;
         pending_ff <= '0;
         open_ff    <= 1'b0;
      end else begin
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         used_ff    <= used_in;
         pending_ff <= pending_in;
         open_ff    <= open_in;
      end
   end

   assign ring = '{rd_ptr: rd_ptr_ff, wr_ptr: wr_ptr_ff, head: head_ff, tail: tail_ff,
                   count: count_ff, used: used_ff, open: open_ff};

endmodule

// ----- sv/pfbr_seq.sv -----
// Command sequencer: answers push starts, walks a pop through the descriptor
// and byte memories, and drives the result register. Depends on pfbr_pkg.
module pfbr_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_take,
   input  logic [pfbr_pkg::ACT_W-1:0]     item_action,
   input  logic [pfbr_pkg::LIMIT_W-1:0]   item_limit,
   input  logic                           push_ok,
   input  pfbr_pkg::ring_state_type       ring,
   input  logic [pfbr_pkg::ID_W-1:0]      desc_id,
   input  logic [pfbr_pkg::LEN_W-1:0]     desc_len,
   input  logic [pfbr_pkg::BYTE_W-1:0]    byte_data,
   output logic [pfbr_pkg::PTR_W-1:0]     byte_rd_addr,
   output pfbr_pkg::pop_done_type         pop_done,
   output logic                           busy,
   output logic                           rsp_valid,
   output logic [pfbr_pkg::STAT_W-1:0]    rsp_status,
   output logic [pfbr_pkg::ID_W-1:0]      rsp_out_id,
   output logic [pfbr_pkg::LEN_W-1:0]     rsp_out_len,
   output logic [pfbr_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_last
);
   import pfbr_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   shown_ff, shown_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [PTR_W-1:0]   cur_ff, cur_in;
   logic [LEN_W-1:0]   desc_shown;
   logic               is_pop, is_start, stream_last;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic               rsp_last_ff, rsp_last_in;

   assign is_pop      = item_take && (item_action == ACT_POP);
   assign is_start    = item_take && (item_action == ACT_PUSH_START);
   assign desc_shown  = (LIMIT_W'(desc_len) <= limit_ff) ? desc_len : limit_ff[LEN_W-1:0];
   assign stream_last = (idx_ff == shown_ff - LEN_W'(1));

   // Read the byte at the read pointer at accept, then one address per cycle
   assign byte_rd_addr = (state_ff == SEQ_IDLE) ? ring.rd_ptr : cur_ff;
   assign cur_in       = byte_next(byte_rd_addr);
   assign busy         = (state_ff != SEQ_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (is_pop && (ring.count != '0)) begin
               state_in = SEQ_DESC;
            end
         end
         SEQ_DESC: begin
            state_in = (desc_shown > LEN_W'(1)) ? SEQ_STREAM : SEQ_IDLE;
         end
         SEQ_STREAM: begin
            if (stream_last) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Outputs and working registers
   always_comb begin
      limit_in      = limit_ff;
      id_in         = id_ff;
      len_in        = len_ff;
      shown_in      = shown_ff;
      idx_in        = idx_ff;
      pop_done      = '{valid: 1'b0, len: '0};
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_ACCEPTED;
      rsp_id_in     = '0;
      rsp_len_in    = '0;
      rsp_byte_in   = '0;
      rsp_bvalid_in = 1'b0;
      rsp_last_in   = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            limit_in = item_limit;
            if (is_start) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = push_ok ? ST_ACCEPTED : ST_REJECTED;
               rsp_last_in   = 1'b1;
            end else if (is_pop && (ring.count == '0)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_EMPTY;
               rsp_last_in   = 1'b1;
            end
         end
         SEQ_DESC: begin
            id_in         = desc_id;
            len_in        = desc_len;
            shown_in      = desc_shown;
            idx_in        = LEN_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_POPPED;
            rsp_id_in     = desc_id;
            rsp_len_in    = desc_len;
            if (desc_shown == '0) begin
               rsp_last_in = 1'b1;
            end else begin
               rsp_byte_in   = byte_data;
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = (desc_shown == LEN_W'(1));
            end
            if (desc_shown <= LEN_W'(1)) begin
               pop_done = '{valid: 1'b1, len: desc_len};
            end
         end
         SEQ_STREAM: begin
            idx_in        = idx_ff + LEN_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_POPPED;
            rsp_id_in     = id_ff;
            rsp_len_in    = len_ff;
            rsp_byte_in   = byte_data;
            rsp_bvalid_in = 1'b1;
            rsp_last_in   = stream_last;
            if (stream_last) begin
               pop_done = '{valid: 1'b1, len: len_ff};
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff      <= limit_in;
      id_ff         <= id_in;
      len_ff        <= len_in;
      shown_ff      <= shown_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_out_len    = rsp_len_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- sv/packet_fifo_byte_ring_core.sv -----
// Top level of the packet FIFO byte ring: byte and descriptor memories,
// ring bookkeeping and the command sequencer. Depends on pfbr_pkg, pfbr_ram,
// pfbr_ring and pfbr_seq.
//
//   channel   direction  handshake               payload
//   request   in         start high, busy low    req_action, req_packet_id,
//                                                req_packet_len, req_data_byte,
//                                                req_out_limit
//   response  out        rsp_valid, one cycle    rsp_status, rsp_out_id, rsp_out_len,
//                                                rsp_out_byte, rsp_byte_valid, rsp_last
//
// Push start and push data words do not raise busy; a push start answers on the
// next cycle. A pop holds busy through its descriptor read and the shown bytes,
// shown being the number of bytes it emits: the byte memory's single read port
// gives one byte a cycle, and the first byte also waits on the descriptor read.
// Results pass through the result register and cannot be held off by the receiver.
// Reset is synchronous; it clears pointers, counts and the sequencer. The
// memories need no clearing pass: only written entries are ever read.
module packet_fifo_byte_ring_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pfbr_pkg::ACT_W-1:0]     req_action,
   input  logic [pfbr_pkg::ID_W-1:0]      req_packet_id,
   input  logic [pfbr_pkg::PLEN_W-1:0]    req_packet_len,
   input  logic [pfbr_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [pfbr_pkg::LIMIT_W-1:0]   req_out_limit,
   output logic                           rsp_valid,
   output logic [pfbr_pkg::STAT_W-1:0]    rsp_status,
   output logic [pfbr_pkg::ID_W-1:0]      rsp_out_id,
   output logic [pfbr_pkg::LEN_W-1:0]     rsp_out_len,
   output logic [pfbr_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_last
);
   import pfbr_pkg::*;

   logic                   item_take;
   logic                   start_take;
   logic                   data_take;
   logic                   push_ok;
   logic                   byte_we;
   logic                   desc_we;
   ring_state_type         ring;
   pop_done_type           pop_done;
   logic [PTR_W-1:0]       byte_rd_addr;
   logic [BYTE_W-1:0]      byte_rd_data;
   logic [DESC_DATA_W-1:0] desc_wr_data;
   logic [DESC_DATA_W-1:0] desc_rd_data;

   // A word is taken whenever start meets an idle sequencer
   assign item_take  = start && !busy;
   assign start_take = item_take && (req_action == ACT_PUSH_START);
   assign data_take  = item_take && (req_action == ACT_PUSH_DATA);

   // Park the descriptor at the tail as soon as the push start is accepted;
   // the tail only advances when the packet commits
   assign desc_we      = start_take && push_ok;
   assign desc_wr_data = {req_packet_id, req_packet_len[LEN_W-1:0]};

   pfbr_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .start_take (start_take),
      .data_take  (data_take),
      .packet_len (req_packet_len),
      .pop_done   (pop_done),
      .push_ok    (push_ok),
      .byte_we    (byte_we),
      .ring       (ring)
   );

   pfbr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (ring.wr_ptr),
      .wr_data (req_data_byte),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   // Always read the head slot; it is stable from pop accept to release
   pfbr_ram #(
      .WIDTH (DESC_DATA_W),
      .DEPTH (MAX_PACKETS)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_we),
      .wr_addr (ring.tail),
      .wr_data (desc_wr_data),
      .rd_addr (ring.head),
      .rd_data (desc_rd_data)
   );

   pfbr_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .item_take      (item_take),
      .item_action    (req_action),
      .item_limit     (req_out_limit),
      .push_ok        (push_ok),
      .ring           (ring),
      .desc_id        (desc_rd_data[DESC_DATA_W-1:LEN_W]),
      .desc_len       (desc_rd_data[LEN_W-1:0]),
      .byte_data      (byte_rd_data),
      .byte_rd_addr   (byte_rd_addr),
      .pop_done       (pop_done),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_len    (rsp_out_len),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // A pop on an empty queue answers with the empty status on the next cycle
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (item_take && (req_action == ACT_POP) && (ring.count == '0))
      |=> (rsp_valid && (rsp_status == ST_EMPTY) && rsp_last))
      else $error("empty pop did not answer with the empty status");

   // Every push start gets exactly one final answer on the next cycle
   a_start_answer: assert property (@(posedge clock) disable iff (reset)
      start_take |=> (rsp_valid && rsp_last && !rsp_byte_valid
                      && ((rsp_status == ST_ACCEPTED) || (rsp_status == ST_REJECTED))))
      else $error("push start answer missing or malformed");

   // A packet is released only by a busy pop, with a committed descriptor
   a_release: assert property (@(posedge clock) disable iff (reset)
      pop_done.valid |-> (busy && (ring.count != '0) && !byte_we && !desc_we))
      else $error("packet released outside a pop");

   // Bytes only appear on popped results
   a_byte_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_valid) |-> (rsp_status == ST_POPPED))
      else $error("byte carried on a non-pop result");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for packet_fifo_byte_ring_core: a shadow copy of the
// byte ring and descriptor queue predicts every response word and a monitor
// compares them field by field. Depends on pfbr_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
   import pfbr_pkg::*;

   // Action code the core must ignore; the package names only the used ones
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   // Number of random words, not counting stray bytes and unused actions
   localparam int RANDOM_WORDS = 24;
   // Quiet cycles after the last expected response: longest pop plus slack
   localparam int DRAIN_CYCLES = 80;

   // One request word as the driver presents it
   typedef struct {
      logic [ACT_W-1:0]   action;
      logic [ID_W-1:0]    id;
      logic [PLEN_W-1:0]  len;
      logic [BYTE_W-1:0]  data;
      logic [LIMIT_W-1:0] limit;
   } ring_word_type;

   // One response word as the core must produce it
   typedef struct {
      status_type         status;
      logic [ID_W-1:0]    id;
      logic [LEN_W-1:0]   len;
      logic [BYTE_W-1:0]  data;
      logic               valid;
      logic               last;
   } ring_reply_type;

   logic clock;
   logic reset = 1'b1;

   // Every input starts at a known value
   logic                start          = 1'b0;
   logic [ACT_W-1:0]    req_action     = '0;
   logic [ID_W-1:0]     req_packet_id  = '0;
   logic [PLEN_W-1:0]   req_packet_len = '0;
   logic [BYTE_W-1:0]   req_data_byte  = '0;
   logic [LIMIT_W-1:0]  req_out_limit  = '0;

   logic                busy;
   logic                rsp_valid;
   logic [STAT_W-1:0]   rsp_status;
   logic [ID_W-1:0]     rsp_out_id;
   logic [LEN_W-1:0]    rsp_out_len;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_last;

   packet_fifo_byte_ring_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_packet_id  (req_packet_id),
      .req_packet_len (req_packet_len),
      .req_data_byte  (req_data_byte),
      .req_out_limit  (req_out_limit),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_len    (rsp_out_len),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last)
   );

   // Words waiting to be driven, and responses the core still owes us
   ring_word_type  pending_words[$];
   ring_reply_type due_replies[$];

   int mismatch_count = 0;
   int stim_words     = 0;
   int gap_left       = 0;
   int calm_words     = 0;
   ring_word_type next_word;

   // ------------------------------------------------------------------
   // Shadow ring: byte store, descriptor queue and their bookkeeping
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0] sh_bytes [BUFFER_BYTES];
   logic [ID_W-1:0]   sh_ids   [MAX_PACKETS];
   logic [LEN_W-1:0]  sh_lens  [MAX_PACKETS];
   logic [PTR_W-1:0]  sh_wr, sh_rd;
   logic [USED_W-1:0] sh_used;
   logic [DESC_W-1:0] sh_head, sh_tail;
   logic [CNT_W-1:0]  sh_count;
   logic [LEN_W-1:0]  sh_pending;
   logic              sh_open;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("testbench: mismatch at %0t ns: %s", $time, msg);
   endtask

   // Close the open packet: its descriptor joins the queue
   task automatic ring_commit();
      sh_tail    = DESC_W'((int'(sh_tail) + 1) % MAX_PACKETS);
      sh_count   = sh_count + 1'b1;
      sh_open    = 1'b0;
      sh_pending = '0;
   endtask

   // Apply one accepted word to the shadow ring and queue the responses it owes
   task automatic ring_apply_word(input ring_word_type w);
      int plen;
      int shown;
      logic [ID_W-1:0] pid;
      case (w.action)
         ACT_PUSH_START: begin
            if (!sh_open && int'(w.len) <= MAX_PACKET &&
                int'(w.len) <= BUFFER_BYTES - int'(sh_used) &&
                int'(sh_count) < MAX_PACKETS) begin
               sh_ids[sh_tail]  = w.id;
               sh_lens[sh_tail] = LEN_W'(w.len);
               if (w.len == '0) begin
                  ring_commit();
               end else begin
                  sh_open    = 1'b1;
                  sh_pending = LEN_W'(w.len);
               end
               due_replies.push_back('{ST_ACCEPTED, 32'd0, 7'd0, 8'd0, 1'b0, 1'b1});
            end else begin
               due_replies.push_back('{ST_REJECTED, 32'd0, 7'd0, 8'd0, 1'b0, 1'b1});
            end
         end
         ACT_PUSH_DATA: begin
            // Stray bytes with nothing open fall through silently
            if (sh_open && sh_pending != '0 && int'(sh_used) < BUFFER_BYTES) begin
               sh_bytes[sh_wr] = w.data;
               sh_wr      = PTR_W'((int'(sh_wr) + 1) % BUFFER_BYTES);
               sh_used    = sh_used + 1'b1;
               sh_pending = sh_pending - 1'b1;
               if (sh_pending == '0) begin
                  ring_commit();
               end
            end
         end
         ACT_POP: begin
            if (sh_count == '0) begin
               due_replies.push_back('{ST_EMPTY, 32'd0, 7'd0, 8'd0, 1'b0, 1'b1});
            end else begin
               pid  = sh_ids[sh_head];
               plen = int'(sh_lens[sh_head]);
               if (plen > MAX_PACKET) plen = MAX_PACKET;
               if (plen > int'(sh_used)) plen = int'(sh_used);
               shown = (plen < int'(w.limit)) ? plen : int'(w.limit);
               // Consume the whole packet, emit only the bytes that fit the limit
               for (int i = 0; i < plen; i++) begin
                  if (i < shown) begin
                     due_replies.push_back('{ST_POPPED, pid, LEN_W'(plen), sh_bytes[sh_rd],
                                             1'b1, (i + 1 == shown)});
                  end
                  sh_rd = PTR_W'((int'(sh_rd) + 1) % BUFFER_BYTES);
               end
               sh_used  = sh_used - USED_W'(plen);
               sh_head  = DESC_W'((int'(sh_head) + 1) % MAX_PACKETS);
               sh_count = sh_count - 1'b1;
               if (shown == 0) begin
                  due_replies.push_back('{ST_POPPED, pid, LEN_W'(plen), 8'd0, 1'b0, 1'b1});
               end
            end
         end
         default: begin
            // Unused action: no state change, no response
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Gap before the next word: mostly none, sometimes short, rarely long,
   // with occasional calm stretches of back-to-back words
   function automatic int pick_gap();
      int roll;
      if (calm_words > 0) begin
         calm_words--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_words = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Most packets short, a few up to the largest allowed
   function automatic logic [PLEN_W-1:0] pick_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return PLEN_W'($urandom_range(0, 8));
      if (roll < 90) return PLEN_W'($urandom_range(9, 32));
      return PLEN_W'($urandom_range(33, MAX_PACKET));
   endfunction

   // Pop limits: zero, below typical lengths, around them, and far above
   function automatic logic [LIMIT_W-1:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 60) return LIMIT_W'($urandom_range(1, 10));
      if (roll < 85) return LIMIT_W'($urandom_range(11, 70));
      return LIMIT_W'($urandom_range(71, 255));
   endfunction

   task automatic queue_word(input logic [ACT_W-1:0] action, input logic [ID_W-1:0] id,
                             input logic [PLEN_W-1:0] len, input logic [BYTE_W-1:0] data,
                             input logic [LIMIT_W-1:0] limit, input bit counted);
      pending_words.push_back('{action, id, len, data, limit});
      if (counted) stim_words++;
   endtask

   // Push start followed by exactly len data bytes; unused fields carry noise
   task automatic queue_packet(input logic [ID_W-1:0] id, input logic [PLEN_W-1:0] len);
      queue_word(ACT_PUSH_START, id, len, BYTE_W'($urandom), LIMIT_W'($urandom), 1'b1);
      repeat (int'(len)) begin
         queue_word(ACT_PUSH_DATA, $urandom, PLEN_W'($urandom), BYTE_W'($urandom),
                    LIMIT_W'($urandom), 1'b1);
      end
   endtask

   task automatic queue_pop(input logic [LIMIT_W-1:0] limit);
      queue_word(ACT_POP, $urandom, PLEN_W'($urandom), BYTE_W'($urandom), limit, 1'b1);
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Driver: a word is taken at an edge with start high and busy low.
   // Predict it right there, then present the next word or idle. start
   // gets at most one assignment per edge so a held-high start never
   // glitches between back-to-back words.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
         sh_wr      = '0;
         sh_rd      = '0;
         sh_used    = '0;
         sh_head    = '0;
         sh_tail    = '0;
         sh_count   = '0;
         sh_pending = '0;
         sh_open    = 1'b0;
      end else begin
         if (start && !busy) begin
            ring_apply_word('{req_action, req_packet_id, req_packet_len,
                              req_data_byte, req_out_limit});
            gap_left = pick_gap();
         end
         // Hold the current word while the core is busy
         if (!start || !busy) begin
            if (gap_left > 0 || pending_words.size() == 0) begin
               if (gap_left > 0) gap_left--;
               start <= 1'b0;
            end else begin
               next_word = pending_words.pop_front();
               start          <= 1'b1;
               req_action     <= next_word.action;
               req_packet_id  <= next_word.id;
               req_packet_len <= next_word.len;
               req_data_byte  <= next_word.data;
               req_out_limit  <= next_word.limit;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every strobed response is matched against the oldest one due
   // ------------------------------------------------------------------
   ring_reply_type got_due;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_replies.size() == 0) begin
            report_mismatch($sformatf("response with nothing due (status %0d)", rsp_status));
         end else begin
            got_due = due_replies.pop_front();
            if (rsp_status !== got_due.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, got_due.status));
            if (rsp_out_id !== got_due.id)
               report_mismatch($sformatf("out_id %h, want %h", rsp_out_id, got_due.id));
            if (rsp_out_len !== got_due.len)
               report_mismatch($sformatf("out_len %0d, want %0d", rsp_out_len, got_due.len));
            if (rsp_out_byte !== got_due.data)
               report_mismatch($sformatf("out_byte %h, want %h", rsp_out_byte, got_due.data));
            if (rsp_byte_valid !== got_due.valid)
               report_mismatch($sformatf("byte_valid %b, want %b",
                                         rsp_byte_valid, got_due.valid));
            if (rsp_last !== got_due.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, got_due.last));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      int roll;
      int blen;
      int rand_base;

      // Directed: empty pop, ignored words, length extremes, zero-length
      // packet, start while a packet is open, pops with zero, short and
      // generous limits
      queue_pop(8'd255);
      queue_word(ACT_PUSH_DATA, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_word(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_word(ACT_PUSH_START, 32'h0000_0000, 8'd0, 8'h00, 8'h00, 1'b1);
      queue_word(ACT_PUSH_START, 32'hFFFF_FFFF, 8'd255, 8'hFF, 8'hFF, 1'b1);
      queue_word(ACT_PUSH_START, 32'h1234_5678, 8'(MAX_PACKET + 1), 8'h00, 8'h00, 1'b1);
      queue_word(ACT_PUSH_START, 32'hA5A5_5A5A, 8'd3, 8'h00, 8'h00, 1'b1);
      queue_word(ACT_PUSH_START, 32'hDEAD_BEEF, 8'd1, 8'h00, 8'h00, 1'b1);
      queue_word(ACT_PUSH_DATA, 32'h0, 8'd0, 8'h00, 8'h00, 1'b1);
      queue_word(ACT_PUSH_DATA, 32'h0, 8'd0, 8'hFF, 8'h00, 1'b1);
      queue_word(ACT_PUSH_DATA, 32'h0, 8'd0, 8'h5A, 8'h00, 1'b1);
      queue_pop(8'd255);
      queue_pop(8'd0);
      queue_packet(32'h8000_0001, 8'd4);
      queue_pop(8'd2);
      queue_packet(32'h7FFF_FFFE, 8'd2);
      queue_pop(8'd255);
      queue_pop(8'd1);

      // Fill the descriptor queue, knock on it once more, then drain it
      repeat (MAX_PACKETS) queue_packet($urandom, PLEN_W'($urandom_range(0, 2)));
      queue_word(ACT_PUSH_START, $urandom, 8'd0, 8'h00, 8'h00, 1'b1);
      repeat (MAX_PACKETS + 1) queue_pop(pick_limit());

      // Fill the byte ring past three quarters: a full-size push must bounce,
      // a zero-length one still fits
      repeat (BUFFER_BYTES / MAX_PACKET - 1) queue_packet($urandom, 8'(MAX_PACKET));
      queue_packet($urandom, 8'd1);
      queue_word(ACT_PUSH_START, $urandom, 8'(MAX_PACKET), 8'h00, 8'h00, 1'b1);
      queue_word(ACT_PUSH_START, $urandom, 8'd0, 8'h00, 8'h00, 1'b1);
      queue_pop(8'(MAX_PACKET));
      queue_pop(8'(MAX_PACKET - 1));
      queue_pop(8'd255);
      queue_pop(pick_limit());
      queue_pop(8'd7);
      queue_pop(8'd255);

      // Random mix: mostly well-formed packets and pops, some broken
      // sequences that leave a packet open, some noise
      rand_base = stim_words;
      while (stim_words - rand_base < RANDOM_WORDS) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            queue_packet($urandom, pick_len());
         end else if (roll < 70) begin
            queue_pop(pick_limit());
         end else if (roll < 80) begin
            // Open a packet, feed it short, then start another over it
            blen = $urandom_range(1, 16);
            queue_word(ACT_PUSH_START, $urandom, PLEN_W'(blen), BYTE_W'($urandom),
                       LIMIT_W'($urandom), 1'b1);
            repeat ($urandom_range(0, blen - 1)) begin
               queue_word(ACT_PUSH_DATA, $urandom, PLEN_W'($urandom), BYTE_W'($urandom),
                          LIMIT_W'($urandom), 1'b1);
            end
            queue_word(ACT_PUSH_START, $urandom, pick_len(), BYTE_W'($urandom),
                       LIMIT_W'($urandom), 1'b1);
         end else if (roll < 90) begin
            queue_word(ACT_W'($urandom_range(0, 2)), $urandom, PLEN_W'($urandom),
                       BYTE_W'($urandom), LIMIT_W'($urandom), 1'b1);
         end else begin
            queue_word(($urandom_range(0, 1) != 0) ? ACT_PUSH_DATA : ACT_UNUSED, $urandom,
                       PLEN_W'($urandom), BYTE_W'($urandom), LIMIT_W'($urandom), 1'b0);
         end
      end
      repeat (MAX_PACKETS + 1) queue_pop(8'd255);

      // Reset once, then release on a clock edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge so the queues are settled
      do @(negedge clock);
      while (pending_words.size() != 0 || start || due_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && due_replies.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/pfbr_pkg.sv
sv/pfbr_ram.sv
sv/pfbr_ring.sv
sv/pfbr_seq.sv
sv/packet_fifo_byte_ring_core.sv
test/testbench.sv
